[rtl/core/gsc_pkg.sv]
`timescale 1ns / 1ps

package gsc_pkg;

  // Fixed field widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned TOTAL_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 20;
  localparam int unsigned CHROMA_W  = 17;
  localparam int unsigned MAG_W     = 17;
  localparam int unsigned INV_W     = 20;
  localparam int unsigned NORM_W    = 25;
  localparam int unsigned SQ_W      = 2 * NORM_W;
  localparam int unsigned SUM_W     = 10;
  localparam int unsigned QUO_W     = 9;

  // Cb/Cr coefficients, Q0.8 rounded to nearest
  localparam logic signed [17:0] CB_R = -18'sd43;
  localparam logic signed [17:0] CB_G = -18'sd85;
  localparam logic signed [17:0] CB_B = 18'sd128;
  localparam logic signed [17:0] CR_R = 18'sd128;
  localparam logic signed [17:0] CR_G = -18'sd107;
  localparam logic signed [17:0] CR_B = -18'sd21;

  // Reference mask red above this marks true skin
  localparam logic [PIX_W-1:0] REF_SKIN_MIN = 8'd5;
  localparam logic [PIX_W-1:0] PAINT_FULL   = 8'd255;

  // Register reset values
  localparam logic [INV_W-1:0] INV_DEV_RESET = 20'd4096;
  localparam logic [INV_W-1:0] THRESH_RESET  = 20'd2048;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE     = 3'd0,
    CFG_MEAN_FIRST     = 3'd1,
    CFG_MEAN_SECOND    = 3'd2,
    CFG_INV_DEV_FIRST  = 3'd3,
    CFG_INV_DEV_SECOND = 3'd4,
    CFG_DIST_THRESHOLD = 3'd5
  } cfg_idx_e;

  // Color conversion modes
  typedef enum logic {
    MODE_CHROMATIC = 1'b0,
    MODE_CBCR      = 1'b1
  } color_mode_e;

  typedef struct packed {
    color_mode_e        color_mode;
    logic signed [15:0] mean_first;
    logic signed [15:0] mean_second;
    logic [INV_W-1:0]   inv_dev_first;
    logic [INV_W-1:0]   inv_dev_second;
    logic [INV_W-1:0]   dist_threshold;
  } cfg_t;

  // One classified pixel in the queue
  typedef struct packed {
    logic             skin;
    logic             ref_skin;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t data;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[rtl/core/gsc_if.sv]
`timescale 1ns / 1ps

interface gsc_pixel_if;
  import gsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] ref_red;
  modport source (output valid, red, green, blue, ref_red, input ready);
  modport sink   (input valid, red, green, blue, ref_red, output ready);
endinterface

interface gsc_result_if;
  import gsc_pkg::*;
  logic               valid;
  logic               ready;
  logic               is_skin;
  logic [PIX_W-1:0]   out_red;
  logic [PIX_W-1:0]   out_green;
  logic [PIX_W-1:0]   out_blue;
  logic [TOTAL_W-1:0] skin_total;
  logic [TOTAL_W-1:0] nonskin_total;
  logic [TOTAL_W-1:0] false_pos_total;
  logic [TOTAL_W-1:0] false_neg_total;
  modport source (output valid, is_skin, out_red, out_green, out_blue, skin_total,
                  nonskin_total, false_pos_total, false_neg_total, input ready);
  modport sink   (input valid, is_skin, out_red, out_green, out_blue, skin_total,
                  nonskin_total, false_pos_total, false_neg_total, output ready);
endinterface

interface gsc_cfg_if;
  import gsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/gsc_front.sv]
`timescale 1ns / 1ps

module gsc_front
  import gsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  gsc_pixel_if.sink  pixel_i,
  input  cfg_t       cfg_i,
  input  qstat_t     qstat_i,
  output push_t      push_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIV    = 6'b000010,
    ST_DIFF   = 6'b000100,
    ST_SCALE  = 6'b001000,
    ST_SQUARE = 6'b010000,
    ST_PUSH   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] step_q;

  logic [PIX_W-1:0]           red_q, green_q, blue_q;
  logic                       ref_skin_q;
  logic                       valid_q;
  logic [SUM_W-1:0]           sum_q;
  logic [SUM_W-1:0]           rem1_q, rem2_q;
  logic [QUO_W-1:0]           quo1_q, quo2_q;
  logic signed [CHROMA_W-1:0] c1_q, c2_q;
  logic [MAG_W-1:0]           mag1_q, mag2_q;
  logic [NORM_W-1:0]          n1_q, n2_q;
  logic [SQ_W-1:0]            sq1_q, sq2_q;

  logic accept;
  assign pixel_i.ready = (state_q == ST_IDLE);
  assign accept = pixel_i.valid && pixel_i.ready;

  // Cb/Cr conversion of the incoming pixel
  logic signed [17:0] r_s, g_s, b_s, cb_w, cr_w;
  assign r_s  = signed'({10'b0, pixel_i.red});
  assign g_s  = signed'({10'b0, pixel_i.green});
  assign b_s  = signed'({10'b0, pixel_i.blue});
  assign cb_w = CB_R * r_s + CB_G * g_s + CB_B * b_s;
  assign cr_w = CR_R * r_s + CR_G * g_s + CR_B * b_s;

  // First quotient bit of the chromatic division: the component may equal the sum
  logic [SUM_W-1:0] sum_w, r_w, g_w;
  logic             qb1, qb2;
  assign sum_w = SUM_W'(pixel_i.red) + SUM_W'(pixel_i.green) + SUM_W'(pixel_i.blue);
  assign r_w   = SUM_W'(pixel_i.red);
  assign g_w   = SUM_W'(pixel_i.green);
  assign qb1   = (r_w >= sum_w);
  assign qb2   = (g_w >= sum_w);

  // One restoring step per cycle for both quotients
  logic [SUM_W:0] dbl1, dbl2;
  logic           ge1, ge2;
  logic [SUM_W:0] sub1, sub2;
  assign dbl1 = {rem1_q, 1'b0};
  assign dbl2 = {rem2_q, 1'b0};
  assign ge1  = (dbl1 >= {1'b0, sum_q});
  assign ge2  = (dbl2 >= {1'b0, sum_q});
  assign sub1 = ge1 ? (dbl1 - {1'b0, sum_q}) : dbl1;
  assign sub2 = ge2 ? (dbl2 - {1'b0, sum_q}) : dbl2;

  // Distance from the mean
  logic signed [17:0] diff1, diff2, neg1, neg2;
  assign diff1 = 18'(c1_q) - 18'(cfg_i.mean_first);
  assign diff2 = 18'(c2_q) - 18'(cfg_i.mean_second);
  assign neg1  = -diff1;
  assign neg2  = -diff2;

  // Scale by inverse deviation (Q8.12); the product's 12 fraction bits are dropped on store
  logic [MAG_W+INV_W-1:0] prod1, prod2;
  assign prod1 = (MAG_W+INV_W)'(mag1_q) * (MAG_W+INV_W)'(cfg_i.inv_dev_first);
  assign prod2 = (MAG_W+INV_W)'(mag2_q) * (MAG_W+INV_W)'(cfg_i.inv_dev_second);

  // Sum of squares against the threshold
  logic [SQ_W:0]   sq_sum;
  logic [SQ_W-8:0] sq_dist;
  logic            skin;
  assign sq_sum  = {1'b0, sq1_q} + {1'b0, sq2_q};
  assign sq_dist = sq_sum[SQ_W:8];
  assign skin    = valid_q && (sq_dist < (SQ_W-7)'(cfg_i.dist_threshold));

  assign push_o.valid         = (state_q == ST_PUSH);
  assign push_o.data.skin     = skin;
  assign push_o.data.ref_skin = ref_skin_q;
  assign push_o.data.red      = red_q;
  assign push_o.data.green    = green_q;
  assign push_o.data.blue     = blue_q;

  // Sequence one pixel at a time
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cfg_i.color_mode == MODE_CHROMATIC && sum_w != '0) state_d = ST_DIV;
          else state_d = ST_DIFF;
        end
      end
      ST_DIV: begin
        if (step_q == 3'd7) state_d = ST_DIFF;
      end
      ST_DIFF:   state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_PUSH;
      ST_PUSH: begin
        if (!qstat_i.full) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV) step_q <= step_q + 3'd1;
      else step_q <= '0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q      <= pixel_i.red;
      green_q    <= pixel_i.green;
      blue_q     <= pixel_i.blue;
      ref_skin_q <= (pixel_i.ref_red > REF_SKIN_MIN);
      sum_q      <= sum_w;
      rem1_q     <= qb1 ? (r_w - sum_w) : r_w;
      rem2_q     <= qb2 ? (g_w - sum_w) : g_w;
      quo1_q     <= {8'b0, qb1};
      quo2_q     <= {8'b0, qb2};
      if (cfg_i.color_mode == MODE_CBCR) begin
        valid_q <= 1'b1;
        c1_q    <= cb_w[CHROMA_W-1:0];
        c2_q    <= cr_w[CHROMA_W-1:0];
      end else begin
        // black pixel in chromatic mode never classifies as skin
        valid_q <= (sum_w != '0);
        c1_q    <= '0;
        c2_q    <= '0;
      end
    end
    if (state_q == ST_DIV) begin
      rem1_q <= sub1[SUM_W-1:0];
      rem2_q <= sub2[SUM_W-1:0];
      quo1_q <= {quo1_q[QUO_W-2:0], ge1};
      quo2_q <= {quo2_q[QUO_W-2:0], ge2};
      if (step_q == 3'd7) begin
        c1_q <= signed'(CHROMA_W'({quo1_q[QUO_W-2:0], ge1}));
        c2_q <= signed'(CHROMA_W'({quo2_q[QUO_W-2:0], ge2}));
      end
    end
    if (state_q == ST_DIFF) begin
      mag1_q <= diff1[17] ? neg1[MAG_W-1:0] : diff1[MAG_W-1:0];
      mag2_q <= diff2[17] ? neg2[MAG_W-1:0] : diff2[MAG_W-1:0];
    end
    if (state_q == ST_SCALE) begin
      n1_q <= prod1[MAG_W+INV_W-1:12];
      n2_q <= prod2[MAG_W+INV_W-1:12];
    end
    if (state_q == ST_SQUARE) begin
      sq1_q <= SQ_W'(n1_q) * SQ_W'(n1_q);
      sq2_q <= SQ_W'(n2_q) * SQ_W'(n2_q);
    end
  end

endmodule

[rtl/core/gsc_queue.sv]
`timescale 1ns / 1ps

module gsc_queue
  import gsc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   pop_i,
  output qstat_t qstat_o,
  output qent_t  head_o
);

  qent_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign qstat_o.full  = (count_q == 2'd2);
  assign qstat_o.empty = (count_q == 2'd0);
  assign do_push       = push_i.valid && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.data;
  end

endmodule

[rtl/core/gsc_back.sv]
`timescale 1ns / 1ps

module gsc_back
  import gsc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  qstat_t        qstat_i,
  input  qent_t         head_i,
  output logic          pop_o,
  gsc_result_if.source  result_o
);

  logic                   out_valid_q;
  logic                   is_skin_q;
  logic [PIX_W-1:0]       red_q, green_q, blue_q;
  logic [COUNT_WIDTH-1:0] skin_cnt_q, nonskin_cnt_q, fp_cnt_q, fn_cnt_q;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == '1) ? v : v + COUNT_WIDTH'(1);
  endfunction

  assign pop_o = !qstat_i.empty && (!out_valid_q || result_o.ready);

  // Track output register occupancy and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      skin_cnt_q    <= '0;
      nonskin_cnt_q <= '0;
      fp_cnt_q      <= '0;
      fn_cnt_q      <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        if (head_i.skin) skin_cnt_q <= sat_inc(skin_cnt_q);
        else nonskin_cnt_q <= sat_inc(nonskin_cnt_q);
        if (head_i.skin && !head_i.ref_skin) fp_cnt_q <= sat_inc(fp_cnt_q);
        if (!head_i.skin && head_i.ref_skin) fn_cnt_q <= sat_inc(fn_cnt_q);
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Paint skin pixels pure red
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      is_skin_q <= head_i.skin;
      red_q     <= head_i.skin ? PAINT_FULL : head_i.red;
      green_q   <= head_i.skin ? '0 : head_i.green;
      blue_q    <= head_i.skin ? '0 : head_i.blue;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.is_skin         = is_skin_q;
  assign result_o.out_red         = red_q;
  assign result_o.out_green       = green_q;
  assign result_o.out_blue        = blue_q;
  assign result_o.skin_total      = TOTAL_W'(skin_cnt_q);
  assign result_o.nonskin_total   = TOTAL_W'(nonskin_cnt_q);
  assign result_o.false_pos_total = TOTAL_W'(fp_cnt_q);
  assign result_o.false_neg_total = TOTAL_W'(fn_cnt_q);

endmodule

[rtl/core/gaussian_skin_pixel_classifier_core.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake           Payload
// pixel_i   in   valid/ready         red, green, blue, ref_red
// result_o  out  valid/ready         is_skin, out_red/green/blue, four totals
// cfg_i     in   valid/ready (=1)    index, data
//
// One pixel is in the classifier at a time: a new pixel is taken only after the
// previous one has passed the front sequencer (difference, scale, square, compare)
// and, in chromatic mode with a non-black pixel, its 8-step divider, and has been
// pushed into the queue.
// A two-entry queue and an output register let the front keep going while the
// result side stalls; the front waits only when the queue is full.
// Reset clears the registers to their defaults and the counters to zero.
module gaussian_skin_pixel_classifier_core
  import gsc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gsc_pixel_if.sink     pixel_i,
  gsc_result_if.source  result_o,
  gsc_cfg_if.sink       cfg_i
);

  cfg_t   cfg_q;
  push_t  push;
  qstat_t qstat;
  qent_t  head;
  logic   pop;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode     <= MODE_CBCR;
      cfg_q.mean_first     <= '0;
      cfg_q.mean_second    <= '0;
      cfg_q.inv_dev_first  <= INV_DEV_RESET;
      cfg_q.inv_dev_second <= INV_DEV_RESET;
      cfg_q.dist_threshold <= THRESH_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_COLOR_MODE:     cfg_q.color_mode     <= color_mode_e'(cfg_i.data[0]);
        CFG_MEAN_FIRST:     cfg_q.mean_first     <= signed'(cfg_i.data[15:0]);
        CFG_MEAN_SECOND:    cfg_q.mean_second    <= signed'(cfg_i.data[15:0]);
        CFG_INV_DEV_FIRST:  cfg_q.inv_dev_first  <= cfg_i.data;
        CFG_INV_DEV_SECOND: cfg_q.inv_dev_second <= cfg_i.data;
        CFG_DIST_THRESHOLD: cfg_q.dist_threshold <= cfg_i.data;
        default: ;
      endcase
    end
  end

  gsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pixel_i (pixel_i),
    .cfg_i   (cfg_q),
    .qstat_i (qstat),
    .push_o  (push)
  );

  gsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .qstat_o (qstat),
    .head_o  (head)
  );

  gsc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qstat_i  (qstat),
    .head_i   (head),
    .pop_o    (pop),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  // Front holds one pixel at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_i.valid && pixel_i.ready) |=> !pixel_i.ready)
    else $error("pixel taken while front busy");

  // Queue status stays consistent
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty");

  // Skin results are painted pure red
  a_paint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.is_skin) |->
    (result_o.out_red == PAINT_FULL && result_o.out_green == '0 && result_o.out_blue == '0))
    else $error("skin pixel not painted");

  // Pop only reaches a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");
`endif

endmodule
